>>> sv/rba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rba_pkg;
  localparam int POOL_SIZE_DEF    = 64;
  localparam int HASH_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF   = 8;

  localparam logic [2:0] ACT_ALLOC      = 3'd0;
  localparam logic [2:0] ACT_ALLOC_HASH = 3'd1;
  localparam logic [2:0] ACT_REUSE      = 3'd2;
  localparam logic [2:0] ACT_RELEASE    = 3'd3;
  localparam logic [2:0] ACT_SHARE      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_TBL_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  block_id;
    logic [63:0] content_hash;
  } req_t;

  typedef struct packed {
    logic [5:0] granted_block;
    logic       hit;
    logic [1:0] status;
    logic [6:0] zero_ref_blocks;
  } rsp_t;

  // Result of a hash table search, handed from the search unit to the sequencer
  typedef struct packed {
    logic found;     // key matched a valid slot
    logic has_free;  // at least one invalid slot seen
  } srch_t;
endpackage
`default_nettype wire

>>> sv/rba_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Hash table: one slot per cycle search with a single key compare.
module rba_hash_table #(
  parameter int HASH_ENTRIES = rba_pkg::HASH_ENTRIES_DEF,
  parameter int BW = 6,
  parameter int HW = (HASH_ENTRIES > 1) ? $clog2(HASH_ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,     // begin search for key
  input  wire logic [63:0]   key,
  output logic               done,      // pulse, result valid
  output rba_pkg::srch_t     res,
  output logic [HW-1:0]      slot,      // matched slot, else lowest free
  output logic [BW-1:0]      target,    // target of matched slot
  input  wire logic          wr,        // write key/target at slot
  input  wire logic [BW-1:0] wr_target
);
  localparam int CW = $clog2(HASH_ENTRIES + 1);

  logic [63:0]   hkey [HASH_ENTRIES];
  logic [BW-1:0] htgt [HASH_ENTRIES];
  logic [HASH_ENTRIES-1:0] hvalid;

  logic          busy;
  logic [CW-1:0] idx;
  logic [HW-1:0] ridx;
  logic          rd_v;
  logic [63:0]   rd_key;
  logic [BW-1:0] rd_tgt;
  logic          rd_valid;
  logic          found, has_free;
  logic [HW-1:0] free_slot;

  assign ridx = idx[HW-1:0];
  assign res  = '{found: found, has_free: has_free};

  // Memory read port, registered data
  always_ff @(posedge clk) begin
    if (busy && (idx < CW'(HASH_ENTRIES))) begin
      rd_key   <= hkey[ridx];
      rd_tgt   <= htgt[ridx];
      rd_valid <= hvalid[ridx];
    end
    if (wr) begin
      hkey[slot] <= key;
      htgt[slot] <= wr_target;
    end
  end

  // Scan sequencer: compare one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      rd_v     <= 1'b0;
      hvalid   <= '0;
      found    <= 1'b0;
      has_free <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr) hvalid[slot] <= 1'b1;
      if (start) begin
        busy     <= 1'b1;
        idx      <= '0;
        rd_v     <= 1'b0;
        found    <= 1'b0;
        has_free <= 1'b0;
      end else if (busy) begin
        rd_v <= idx < CW'(HASH_ENTRIES);
        idx  <= idx + 1'b1;
        if (rd_v) begin
          if (rd_valid && rd_key == key && !found) begin
            found  <= 1'b1;
            slot   <= free_slot;
            target <= rd_tgt;
          end
          if (!rd_valid && !has_free && !found) begin
            has_free <= 1'b1;
            slot     <= free_slot;
          end
        end
        if (idx == CW'(HASH_ENTRIES)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Slot index of the data now in the read register
  always_ff @(posedge clk) begin
    free_slot <= ridx;
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("search done without search");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("search still busy at done");
  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    wr |-> !busy) else $error("table write during search");
`endif
endmodule
`default_nettype wire

>>> sv/rba_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// Block pool: reference counts, free stack and zero count.
// Reclaim scans counts from the top index down, a read then a check per block.
// After reset a clearing pass zeroes the counts and refills the stack; idle
// stays low meanwhile.
module rba_pool #(
  parameter int POOL_SIZE  = rba_pkg::POOL_SIZE_DEF,
  parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF,
  parameter int BW = $clog2(POOL_SIZE),
  parameter int TW = $clog2(POOL_SIZE + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          alloc,     // start an allocation
  input  wire logic          incr,      // add a reference to blk
  input  wire logic          decr,      // drop a reference of blk
  input  wire logic [BW-1:0] blk,
  output logic               idle,      // ready for a new operation
  output logic               done,      // operation finished
  output logic               ok,        // allocation granted
  output logic [BW-1:0]      granted,
  output logic [TW-1:0]      zero_count
);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_POP = 3'd2,
                         S_RDC = 3'd3, S_UPD = 3'd4, S_CNT = 3'd5,
                         S_PRE = 3'd6, S_INIT = 3'd7;

  logic [COUNT_BITS-1:0] cnt [POOL_SIZE];
  logic [BW-1:0]         stk [POOL_SIZE];
  logic [2:0]            state;
  logic [TW-1:0]         top;
  logic [TW-1:0]         sidx;       // scan position + 1, clear index in init
  logic [BW-1:0]         sblk;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [BW-1:0]         rd_stk;
  logic                  is_incr;
  logic [BW-1:0]         cur;

  assign sblk = BW'(sidx - 1'b1);
  assign idle = (state == S_IDLE);

  // Count memory: one read and one write port
  always_ff @(posedge clk) begin
    unique case (state)
      S_SCAN:  rd_cnt <= cnt[sblk];
      default: rd_cnt <= cnt[cur];
    endcase
    rd_stk <= stk[BW'(top - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      done       <= 1'b0;
      top        <= TW'(POOL_SIZE);
      zero_count <= TW'(POOL_SIZE);
      sidx       <= '0;
      ok         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          sidx <= sidx + 1'b1;
          if (sidx == TW'(POOL_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (alloc) begin
            ok <= 1'b0;
            if (top == '0) begin
              sidx  <= TW'(POOL_SIZE);
              state <= S_SCAN;
            end else begin
              state <= S_POP;
            end
          end else if (incr || decr) begin
            ok      <= 1'b0;
            cur     <= blk;
            is_incr <= incr;
            state   <= S_RDC;
          end
        end
        // read issued at sidx-1 in this cycle; evaluated next cycle
        S_SCAN: begin
          cur   <= sblk;
          state <= S_CNT;
        end
        S_CNT: begin
          if (rd_cnt == '0) begin
            top <= top + 1'b1;
          end
          if (sidx == TW'(1)) begin
            state <= (top == '0 && rd_cnt != '0) ? S_IDLE : S_PRE;
            done  <= (top == '0 && rd_cnt != '0);
          end else begin
            sidx  <= sidx - 1'b1;
            state <= S_SCAN;
          end
        end
        // stack top is read again after the last push
        S_PRE: begin
          state <= S_POP;
        end
        S_POP: begin
          // rd_stk holds stack top (read last cycle with current top)
          state <= S_RDC;
          top   <= top - 1'b1;
          cur   <= rd_stk;
          is_incr <= 1'b0;
          ok    <= 1'b1;
          granted <= rd_stk;
        end
        S_RDC: begin
          state <= S_UPD;
        end
        default: begin // S_UPD: rd_cnt holds count of cur
          state <= S_IDLE;
          done  <= 1'b1;
          if (ok) begin
            if (rd_cnt == '0) zero_count <= zero_count - 1'b1;
          end else if (is_incr) begin
            if (rd_cnt == '0) zero_count <= zero_count - 1'b1;
          end else if (rd_cnt == COUNT_BITS'(1)) begin
            zero_count <= zero_count + 1'b1;
          end
        end
      endcase
    end
  end

  // Memory writes: clearing pass, stack push in scan, count update
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      cnt[sidx[BW-1:0]] <= '0;
      stk[sidx[BW-1:0]] <= sidx[BW-1:0];
    end
    if (state == S_CNT && rd_cnt == '0) begin
      stk[top[BW-1:0]] <= cur;
    end
    if (state == S_UPD) begin
      if (ok) begin
        cnt[cur] <= COUNT_BITS'(1);
      end else if (is_incr) begin
        if (rd_cnt != CMAX) cnt[cur] <= rd_cnt + 1'b1;
      end else if (rd_cnt != '0) begin
        cnt[cur] <= rd_cnt - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= TW'(POOL_SIZE)) else $error("free stack overflow");
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    zero_count <= TW'(POOL_SIZE)) else $error("zero count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> top != '0) else $error("pop from empty stack");
`endif
endmodule
`default_nettype wire

>>> sv/refcounted_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Payload       | Handshake
// in      | input     | rba_pkg::req_t| in_valid / in_ready
// out     | output    | rba_pkg::rsp_t| out_valid / out_ready
// One transaction at a time. Release and allocate go to the pool, and an
// allocation with an empty free stack runs a reclaim scan first. Hash actions
// search the table one slot a cycle; share then writes it if the key or a free
// slot was found, and for reuse and hashed allocate a hit adds a reference and
// an allocating miss allocates. Unused codes go straight to the result. Reset
// is synchronous and is followed by a clearing pass; in_ready stays low during
// it and until the result is taken.
module refcounted_block_allocator #(
  parameter int POOL_SIZE    = rba_pkg::POOL_SIZE_DEF,
  parameter int HASH_ENTRIES = rba_pkg::HASH_ENTRIES_DEF,
  parameter int COUNT_BITS   = rba_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rba_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rba_pkg::rsp_t      out_data
);
  localparam int BW = $clog2(POOL_SIZE);
  localparam int TW = $clog2(POOL_SIZE + 1);
  localparam int HW = (HASH_ENTRIES > 1) ? $clog2(HASH_ENTRIES) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SRCH = 3'd1, S_POOL = 3'd2,
                         S_OUT = 3'd3, S_WAIT = 3'd4;

  logic [2:0]     state;
  rba_pkg::req_t  req;
  logic           h_start, h_done, h_wr;
  rba_pkg::srch_t h_res;
  logic [HW-1:0]  h_slot;
  logic [BW-1:0]  h_tgt;
  logic           p_alloc, p_incr, p_decr, p_done, p_ok, p_idle;
  logic [BW-1:0]  p_blk, p_granted;
  logic [TW-1:0]  p_zero;

  assign in_ready = (state == S_IDLE) && !out_valid && p_idle;

  rba_hash_table #(.HASH_ENTRIES(HASH_ENTRIES), .BW(BW), .HW(HW)) u_tbl (
    .clk, .rst, .start(h_start), .key(req.content_hash), .done(h_done),
    .res(h_res), .slot(h_slot), .target(h_tgt), .wr(h_wr),
    .wr_target(req.block_id[BW-1:0])
  );

  rba_pool #(.POOL_SIZE(POOL_SIZE), .COUNT_BITS(COUNT_BITS), .BW(BW),
             .TW(TW)) u_pool (
    .clk, .rst, .alloc(p_alloc), .incr(p_incr), .decr(p_decr), .blk(p_blk),
    .idle(p_idle), .done(p_done), .ok(p_ok), .granted(p_granted),
    .zero_count(p_zero)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      h_start   <= 1'b0;
      h_wr      <= 1'b0;
      p_alloc   <= 1'b0;
      p_incr    <= 1'b0;
      p_decr    <= 1'b0;
    end else begin
      h_start <= 1'b0;
      h_wr    <= 1'b0;
      p_alloc <= 1'b0;
      p_incr  <= 1'b0;
      p_decr  <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            out_data <= '0;
            unique case (in_data.action) inside
              rba_pkg::ACT_ALLOC: begin
                p_alloc <= 1'b1;
                state   <= S_POOL;
              end
              rba_pkg::ACT_ALLOC_HASH, rba_pkg::ACT_REUSE: begin
                h_start <= 1'b1;
                state   <= S_SRCH;
              end
              rba_pkg::ACT_RELEASE: begin
                if (32'(in_data.block_id) < POOL_SIZE) begin
                  p_decr <= 1'b1;
                  p_blk  <= in_data.block_id[BW-1:0];
                  state  <= S_POOL;
                end else state <= S_OUT;
              end
              rba_pkg::ACT_SHARE: begin
                if (32'(in_data.block_id) < POOL_SIZE) begin
                  h_start <= 1'b1;
                  state   <= S_SRCH;
                end else state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_SRCH: begin
          if (h_done) begin
            if (req.action == rba_pkg::ACT_SHARE) begin
              if (h_res.found || h_res.has_free) h_wr <= 1'b1;
              else out_data.status <= rba_pkg::ST_TBL_FULL;
              state <= S_OUT;
            end else if (h_res.found) begin
              out_data.hit <= 1'b1;
              out_data.granted_block <= 6'(h_tgt);
              p_incr <= 1'b1;
              p_blk  <= h_tgt;
              state  <= S_POOL;
            end else if (req.action == rba_pkg::ACT_ALLOC_HASH) begin
              p_alloc <= 1'b1;
              state   <= S_POOL;
            end else state <= S_OUT;
          end
        end
        S_POOL: begin
          if (p_done) begin
            if (req.action == rba_pkg::ACT_ALLOC ||
                (req.action == rba_pkg::ACT_ALLOC_HASH && !out_data.hit)) begin
              if (p_ok) out_data.granted_block <= 6'(p_granted);
              else out_data.status <= rba_pkg::ST_NO_FREE;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // go through S_WAIT first so the zero count has settled
          state <= S_WAIT;
        end
        default: begin
          out_data.zero_ref_blocks <= 7'(p_zero);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({p_alloc, p_incr, p_decr, h_start}) <= 1)
    else $error("two units started");
  a_no_hit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.status != rba_pkg::ST_OK))
    else $error("hit with error status");
`endif
endmodule
`default_nettype wire
